### hdl/scn_pkg.sv
// shared types and constants for the sparse coordinate normalizer
package scn_pkg;

   localparam int COORD_W    = 16;
   localparam int VALUE_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // request kinds
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // register index (byte address bit 2)
   localparam logic CSR_IDX_SWAP = 1'b0;

   typedef struct packed {
      logic                      req_type;
      logic [COORD_W-1:0]        row_index;
      logic [COORD_W-1:0]        col_index;
      logic signed [VALUE_W-1:0] entry_value;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0]        out_row;
      logic [COORD_W-1:0]        out_col;
      logic signed [VALUE_W-1:0] out_value;
      logic                      last;
      logic                      empty_res;
      logic                      overflowed;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_FLUSH,
      ST_LAST
   } state_type;

   // command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic pop;
      logic push;
   } chain_ctl_type;

   // command to the merge unit
   typedef struct packed {
      logic take;
      logic flush;
      logic fin;
   } merge_ctl_type;

   // merge unit status
   typedef struct packed {
      logic push;
      logic emit;
      logic last;
      logic empty;
   } merge_out_type;

endpackage

### hdl/sparse_coo_normalize.sv
// sparse coordinate list collector: sorted insertion chain, merge and emit
//
// req channel (req_valid / req_stall / req_data): a load transfer stores one
// (row, col, value) entry; zero values are ignored, and when the swap register
// is set row and column trade places, and loads may follow back to back.
// each load is inserted at its sorted place in a row of MAX_ENTRIES cells. a
// load into a full store is dropped and sets a sticky overflow flag that is
// reported on every later result.
// a finish transfer drains the chain head through the merge unit, which sums
// entries at the same position and drops zero sums; survivors are written back
// to the chain tail so the store keeps the normalized list. results go out on
// the rsp channel in row/column order, the final one with last set; an empty
// list gives a single result with empty_res set. the chain drains one entry a
// cycle while the rsp register can take a result; req_stall is high during a
// finish. rsp channel: one output register; the merge unit only advances in
// cycles where that register is free or being taken, so rsp_stall simply
// pauses it. csr: APB-style, one register (swap) at byte address 0, to be
// written when idle; the block itself does not enforce it. reset (synchronous)
// empties the store and clears the overflow flag and swap.
module sparse_coo_normalize #(
   parameter int MAX_ENTRIES = 64,
   parameter int COORD_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  scn_pkg::req_payload_type            req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output scn_pkg::rsp_payload_type            rsp_data,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scn_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [scn_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [scn_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // stored coordinate width: input fields carry 16 bits at most
   localparam int CW    = (COORD_BITS < scn_pkg::COORD_W) ? COORD_BITS : scn_pkg::COORD_W;
   localparam int KEY_W = 2 * CW;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   scn_pkg::state_type          state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            rest_ff, rest_in;
   logic                        ovf_ff, ovf_in;
   logic                        swap_ff, swap_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   scn_pkg::rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic                        step;
   logic                        full;
   logic                        load_go;
   logic                        fin_go;
   logic                        csr_wr;
   logic [CW-1:0]               ld_row;
   logic [CW-1:0]               ld_col;
   logic [KEY_W-1:0]            ld_key;
   logic [KEY_W-1:0]            new_key;
   logic [scn_pkg::VALUE_W-1:0] new_val;
   scn_pkg::chain_ctl_type      chain_ctl;
   scn_pkg::merge_ctl_type      merge_ctl;
   scn_pkg::merge_out_type      merge_st;
   logic [KEY_W-1:0]            push_key;
   logic [scn_pkg::VALUE_W-1:0] push_val;
   logic [KEY_W-1:0]            pend_key;
   logic [scn_pkg::VALUE_W-1:0] pend_val;

   // cell row signals
   logic [KEY_W-1:0]            cell_key [MAX_ENTRIES];
   logic [scn_pkg::VALUE_W-1:0] cell_val [MAX_ENTRIES];
   logic                        cell_gt  [MAX_ENTRIES];
   logic                        cell_occ [MAX_ENTRIES];

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign swap_in    = (csr_wr && (csr_paddr[2] == scn_pkg::CSR_IDX_SWAP))
                       ? csr_pwdata[0] : swap_ff;
   assign csr_prdata = (csr_paddr[2] == scn_pkg::CSR_IDX_SWAP)
                       ? {{(scn_pkg::CSR_DATA_W-1){1'b0}}, swap_ff} : '0;

   // ---------------- load path ----------------
   assign ld_row  = req_data.row_index[CW-1:0];
   assign ld_col  = req_data.col_index[CW-1:0];
   assign ld_key  = swap_ff ? {ld_col, ld_row} : {ld_row, ld_col};
   assign full    = (count_ff == CNT_W'(MAX_ENTRIES));

   // the merge unit only moves when the output register can take a result
   assign step = !rsp_valid_ff || !rsp_stall;

   // ---------------- control outputs ----------------
   always_comb begin
      req_stall       = 1'b1;
      load_go         = 1'b0;
      fin_go          = 1'b0;
      merge_ctl       = '0;
      unique case (state_ff)
         scn_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            load_go   = req_valid && (req_data.req_type == scn_pkg::REQ_LOAD)
                        && (req_data.entry_value != '0);
            fin_go    = req_valid && (req_data.req_type == scn_pkg::REQ_FINISH);
         end
         scn_pkg::ST_DRAIN: begin
            merge_ctl.take = step && (rest_ff != '0);
         end
         scn_pkg::ST_FLUSH: begin
            merge_ctl.flush = step;
         end
         scn_pkg::ST_LAST: begin
            merge_ctl.fin = step;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // insert while loading, otherwise pop/push driven by the merge unit
   assign chain_ctl.ins  = load_go && !full;
   assign chain_ctl.pop  = merge_ctl.take;
   assign chain_ctl.push = merge_st.push;

   assign new_key = (state_ff == scn_pkg::ST_IDLE) ? ld_key : push_key;
   assign new_val = (state_ff == scn_pkg::ST_IDLE) ? req_data.entry_value : push_val;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scn_pkg::ST_IDLE: begin
            if (fin_go) begin
               state_in = scn_pkg::ST_DRAIN;
            end
         end
         scn_pkg::ST_DRAIN: begin
            // leave once the last unprocessed entry has been popped
            if ((rest_ff == '0) || (step && (rest_ff == CNT_W'(1)))) begin
               state_in = scn_pkg::ST_FLUSH;
            end
         end
         scn_pkg::ST_FLUSH: begin
            if (step) begin
               state_in = scn_pkg::ST_LAST;
            end
         end
         scn_pkg::ST_LAST: begin
            if (step) begin
               state_in = scn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scn_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- counters and flags ----------------
   // occupied length: +1 on insert or survivor push, -1 on head pop
   assign count_in = count_ff + CNT_W'(chain_ctl.ins) + CNT_W'(chain_ctl.push)
                     - CNT_W'(chain_ctl.pop);
   // entries still waiting to go through the merge unit
   assign rest_in  = fin_go ? count_ff
                   : (merge_ctl.take ? rest_ff - CNT_W'(1) : rest_ff);
   assign ovf_in   = ovf_ff || (load_go && full);

   // ---------------- cell chain ----------------
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic                        left_occ;
      logic                        left_gt;
      logic [KEY_W-1:0]            left_key;
      logic [scn_pkg::VALUE_W-1:0] left_val;
      logic                        right_occ;
      logic [KEY_W-1:0]            right_key;
      logic [scn_pkg::VALUE_W-1:0] right_val;

      assign cell_occ[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_occ = 1'b1;
         assign left_gt  = 1'b0;
         assign left_key = '0;
         assign left_val = '0;
      end else begin : g_body
         assign left_occ = cell_occ[i-1];
         assign left_gt  = cell_gt[i-1];
         assign left_key = cell_key[i-1];
         assign left_val = cell_val[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign right_occ = 1'b0;
         assign right_key = '0;
         assign right_val = '0;
      end else begin : g_inner
         assign right_occ = cell_occ[i+1];
         assign right_key = cell_key[i+1];
         assign right_val = cell_val[i+1];
      end

      scn_cell #(
         .KEY_BITS (KEY_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (chain_ctl),
         .occ       (cell_occ[i]),
         .left_occ  (left_occ),
         .right_occ (right_occ),
         .left_gt   (left_gt),
         .left_key  (left_key),
         .left_val  (left_val),
         .right_key (right_key),
         .right_val (right_val),
         .new_key   (new_key),
         .new_val   (new_val),
         .gt        (cell_gt[i]),
         .key       (cell_key[i]),
         .val       (cell_val[i])
      );
   end

   // ---------------- merge unit on the chain head ----------------
   scn_merge #(
      .KEY_BITS (KEY_W)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctl      (merge_ctl),
      .head_key (cell_key[0]),
      .head_val (cell_val[0]),
      .status   (merge_st),
      .push_key (push_key),
      .push_val (push_val),
      .pend_key (pend_key),
      .pend_val (pend_val)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (merge_st.emit) begin
         rsp_valid_in = 1'b1;
         if (merge_st.empty) begin
            rsp_data_in.out_row   = '0;
            rsp_data_in.out_col   = '0;
            rsp_data_in.out_value = '0;
         end else begin
            rsp_data_in.out_row   = scn_pkg::COORD_W'(pend_key[KEY_W-1:CW]);
            rsp_data_in.out_col   = scn_pkg::COORD_W'(pend_key[CW-1:0]);
            rsp_data_in.out_value = pend_val;
         end
         rsp_data_in.last       = merge_st.last;
         rsp_data_in.empty_res  = merge_st.empty;
         rsp_data_in.overflowed = ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scn_pkg::ST_IDLE;
         count_ff     <= '0;
         rest_ff      <= '0;
         ovf_ff       <= 1'b0;
         swap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rest_ff      <= rest_in;
         ovf_ff       <= ovf_in;
         swap_ff      <= swap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hdl/scn_cell.sv
// one storage cell of the sorted entry chain
module scn_cell #(
   parameter int KEY_BITS = 32
) (
   input  logic                          clock,
   input  scn_pkg::chain_ctl_type        ctl,
   input  logic                          occ,
   input  logic                          left_occ,
   input  logic                          right_occ,
   input  logic                          left_gt,
   input  logic [KEY_BITS-1:0]           left_key,
   input  logic [scn_pkg::VALUE_W-1:0]   left_val,
   input  logic [KEY_BITS-1:0]           right_key,
   input  logic [scn_pkg::VALUE_W-1:0]   right_val,
   input  logic [KEY_BITS-1:0]           new_key,
   input  logic [scn_pkg::VALUE_W-1:0]   new_val,
   output logic                          gt,
   output logic [KEY_BITS-1:0]           key,
   output logic [scn_pkg::VALUE_W-1:0]   val
);

   logic [KEY_BITS-1:0]         key_ff, key_in;
   logic [scn_pkg::VALUE_W-1:0] val_ff, val_in;

   // empty cells sort after everything
   assign gt  = !occ || (key_ff > new_key);
   assign key = key_ff;
   assign val = val_ff;

   always_comb begin
      key_in = key_ff;
      val_in = val_ff;
      if (ctl.ins) begin
         if (left_gt) begin
            key_in = left_key;
            val_in = left_val;
         end else if (gt) begin
            key_in = new_key;
            val_in = new_val;
         end
      end else if (ctl.pop) begin
         if (occ && right_occ) begin
            key_in = right_key;
            val_in = right_val;
         end else if (occ && ctl.push) begin
            key_in = new_key;
            val_in = new_val;
         end
      end else if (ctl.push) begin
         if (!occ && left_occ) begin
            key_in = new_key;
            val_in = new_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      val_ff <= val_in;
   end

endmodule

### hdl/scn_merge.sv
// sums equal-position entries off the chain head and holds back one survivor
module scn_merge #(
   parameter int KEY_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  scn_pkg::merge_ctl_type        ctl,
   input  logic [KEY_BITS-1:0]           head_key,
   input  logic [scn_pkg::VALUE_W-1:0]   head_val,
   output scn_pkg::merge_out_type        status,
   output logic [KEY_BITS-1:0]           push_key,
   output logic [scn_pkg::VALUE_W-1:0]   push_val,
   output logic [KEY_BITS-1:0]           pend_key,
   output logic [scn_pkg::VALUE_W-1:0]   pend_val
);

   logic                        acc_valid_ff, acc_valid_in;
   logic [KEY_BITS-1:0]         acc_key_ff, acc_key_in;
   logic [scn_pkg::VALUE_W-1:0] acc_sum_ff, acc_sum_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [KEY_BITS-1:0]         pend_key_ff, pend_key_in;
   logic [scn_pkg::VALUE_W-1:0] pend_val_ff, pend_val_in;
   logic                        same_key;
   logic                        surv;

   assign same_key = acc_valid_ff && (acc_key_ff == head_key);
   // accumulator closes with a nonzero sum
   assign surv = ((ctl.take && !same_key) || ctl.flush) && acc_valid_ff
                 && (acc_sum_ff != '0);

   assign status.push  = surv;
   assign status.emit  = (surv && pend_valid_ff) || ctl.fin;
   assign status.last  = ctl.fin;
   assign status.empty = ctl.fin && !pend_valid_ff;

   assign push_key = acc_key_ff;
   assign push_val = acc_sum_ff;
   assign pend_key = pend_key_ff;
   assign pend_val = pend_val_ff;

   always_comb begin
      acc_valid_in  = acc_valid_ff;
      acc_key_in    = acc_key_ff;
      acc_sum_in    = acc_sum_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      pend_val_in   = pend_val_ff;
      if (ctl.take) begin
         if (same_key) begin
            acc_sum_in = acc_sum_ff + head_val;
         end else begin
            acc_valid_in = 1'b1;
            acc_key_in   = head_key;
            acc_sum_in   = head_val;
         end
      end
      if (ctl.flush) begin
         acc_valid_in = 1'b0;
      end
      if (surv) begin
         pend_valid_in = 1'b1;
         pend_key_in   = acc_key_ff;
         pend_val_in   = acc_sum_ff;
      end
      if (ctl.fin) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff  <= acc_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      acc_key_ff  <= acc_key_in;
      acc_sum_ff  <= acc_sum_in;
      pend_key_ff <= pend_key_in;
      pend_val_ff <= pend_val_in;
   end

endmodule
